// ===== rtl/wps_pkg.sv =====
package wps_pkg;

    // Payload of one input transaction and of one result transaction.
    typedef struct packed {
        logic              op;
        logic [2:0]        wp_index;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic signed [15:0] yaw_angle;
    } wps_in_t;

    typedef struct packed {
        logic [11:0]        linear_cmd;
        logic signed [15:0] angular_cmd;
        logic [2:0]         target_slot;
        logic               route_done;
    } wps_out_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_FETCH,
        ST_CORDIC,
        ST_GAIN,
        ST_DIST,
        ST_ANG_KI,
        ST_ANG_DR,
        ST_ANG_KD,
        ST_ANG_KP,
        ST_ANG_WAIT,
        ST_LIN_KI,
        ST_LIN_DR,
        ST_LIN_KD,
        ST_LIN_KP,
        ST_LIN_SUM,
        ST_DONE
    } wps_state_t;

    // Opcode and register indexes.
    localparam logic OP_LOAD = 1'b0;

    localparam logic [2:0] REG_KP_LIN    = 3'd0;
    localparam logic [2:0] REG_KI_LIN    = 3'd1;
    localparam logic [2:0] REG_KD_LIN    = 3'd2;
    localparam logic [2:0] REG_KP_ANG    = 3'd3;
    localparam logic [2:0] REG_KI_ANG    = 3'd4;
    localparam logic [2:0] REG_KD_ANG    = 3'd5;
    localparam logic [2:0] REG_RATE      = 3'd6;
    localparam logic [2:0] REG_ROUTE_LEN = 3'd7;

    // Datapath widths.
    localparam int XY_W   = 34;
    localparam int Z_W    = 21;
    localparam int E_W    = 22;
    localparam int A_W    = 34;
    localparam int B_W    = 18;
    localparam int P_W    = A_W + B_W;
    localparam int DIVN_W = 30;
    localparam int RATE_W = 10;
    localparam int ACC_W  = 48;

    // Fixed constants of the control law.
    localparam int PI_Q16       = 205887;
    localparam int PI_Q13       = 25736;
    localparam int TWO_PI_Q13   = 51472;
    localparam int GAIN_INV_Q16 = 39797;
    localparam int ARRIVE_TOL   = 13;
    localparam int ALIGN_TOL    = 82;
    localparam int NEAR_DIST    = 26;
    localparam int INTEG_DIST   = 128;
    localparam int QUARTER_PI   = 6434;

    // Arctangent of 2**-i in Q16 radians.
    function automatic logic [16:0] wps_atan(input logic [4:0] idx);
        logic [16:0] r;
        case (idx)
            5'd0:    r = 17'd51472;
            5'd1:    r = 17'd30386;
            5'd2:    r = 17'd16055;
            5'd3:    r = 17'd8150;
            5'd4:    r = 17'd4091;
            5'd5:    r = 17'd2047;
            5'd6:    r = 17'd1024;
            5'd7:    r = 17'd512;
            5'd8:    r = 17'd256;
            5'd9:    r = 17'd128;
            5'd10:   r = 17'd64;
            5'd11:   r = 17'd32;
            5'd12:   r = 17'd16;
            5'd13:   r = 17'd8;
            5'd14:   r = 17'd4;
            5'd15:   r = 17'd2;
            5'd16:   r = 17'd1;
            default: r = 17'd0;
        endcase
        return r;
    endfunction

    // Saturate to a 16-bit signed value.
    function automatic logic signed [15:0] wps_sat16(input logic signed [ACC_W-1:0] v);
        logic signed [15:0] r;
        if (v > ACC_W'(32767))
            r = 16'sd32767;
        else if (v < -ACC_W'(32768))
            r = -16'sd32768;
        else
            r = v[15:0];
        return r;
    endfunction

endpackage

// ===== rtl/wps_ram.sv =====
module wps_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
)
(
    input  logic                                clk,
    input  logic                                we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                    wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                    rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/wps_mul.sv =====
module wps_mul import wps_pkg::*;
(
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [A_W-1:0] a,
    input  logic signed [B_W-1:0] b,
    output logic signed [P_W-1:0] prod
);

    logic signed [P_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= P_W'(a) * P_W'(b);
        end
    end

    assign prod = prod_reg;

endmodule

// ===== rtl/wps_div.sv =====
module wps_div import wps_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIVN_W-1:0] dividend,
    input  logic [RATE_W-1:0] divisor,
    output logic [DIVN_W-1:0] quotient,
    output logic              done
);

    localparam int CNT_W = $clog2(DIVN_W + 1);

    logic [RATE_W-1:0] den_reg;
    logic [RATE_W-1:0] rem_reg;
    logic [DIVN_W-1:0] quo_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [RATE_W:0]   trial;
    logic              fits;

    // One quotient bit per cycle, restoring form.
    assign trial = {rem_reg, quo_reg[DIVN_W-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIVN_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? RATE_W'(trial - {1'b0, den_reg}) : trial[RATE_W-1:0];
            quo_reg <= {quo_reg[DIVN_W-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== rtl/wps_cordic.sv =====
module wps_cordic import wps_pkg::*;
#(
    parameter int CORDIC_STEPS = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic signed [16:0]    dx,
    input  logic signed [16:0]    dy,
    output logic signed [XY_W-1:0] mag_raw,
    output logic signed [Z_W-1:0] angle,
    output logic                  done
);

    localparam int CW = $clog2(CORDIC_STEPS);

    logic signed [XY_W-1:0] x_reg, y_reg;
    logic signed [Z_W-1:0]  z_reg;
    logic [CW-1:0]          cnt_reg;
    logic                   busy_reg;
    logic                   done_reg;
    logic signed [XY_W-1:0] x0, y0, xs, ys;
    logic signed [Z_W-1:0]  t;

    assign x0 = XY_W'(dx) <<< 12;
    assign y0 = XY_W'(dy) <<< 12;
    assign xs = x_reg >>> cnt_reg;
    assign ys = y_reg >>> cnt_reg;
    assign t  = $signed(Z_W'(wps_atan(5'(cnt_reg))));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CW'(CORDIC_STEPS - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            // Vectors in the left half plane are first turned by pi.
            if (x0 < 0)
            begin
                x_reg <= -x0;
                y_reg <= -y0;
                z_reg <= (y0 >= 0) ? Z_W'(PI_Q16) : -Z_W'(PI_Q16);
            end
            else
            begin
                x_reg <= x0;
                y_reg <= y0;
                z_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (y_reg >= 0)
            begin
                x_reg <= x_reg + ys;
                y_reg <= y_reg - xs;
                z_reg <= z_reg + t;
            end
            else
            begin
                x_reg <= x_reg - ys;
                y_reg <= y_reg + xs;
                z_reg <= z_reg - t;
            end
        end
    end

    assign mag_raw = x_reg;
    assign angle   = z_reg;
    assign done    = done_reg;

endmodule

// ===== rtl/waypoint_pid_steering.sv =====
// Waypoint follower for a differential-drive robot. A load transaction (op 0)
// writes one waypoint into the route table and returns no result. A pose
// transaction (op 1) returns one result with a forward and a turn velocity
// command toward the current waypoint, its slot, and a flag that is set once
// the final waypoint has been reached; on arrival at an earlier waypoint the
// target advances and all PID state clears. Gains and rates must be written
// through cfg_we/cfg_addr/cfg_wdata only while the block is idle; the user is
// bound to this, the block itself does not enforce it. A pose transaction
// keeps the input closed from acceptance until its result has moved into the
// output register, which also waits while the previous result still waits for
// out_ready. The work is done by the iterative CORDIC that finds bearing and
// distance, one shared multiplier that forms every gain product in turn, and
// a one bit per cycle divider for the turn integral. A pose that arrives skips
// the PID steps, and one whose heading is aligned skips the turn steps and the
// divider; both finish sooner. A finished result sits in the output register
// while the next transaction is accepted.
module waypoint_pid_steering import wps_pkg::*;
#(
    parameter int MAX_WAYPOINTS = 8,
    parameter int CORDIC_STEPS  = 16,
    parameter int LIN_LIMIT     = 2048,
    parameter int ANG_LIMIT     = 17408
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  wps_in_t     in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output wps_out_t    out_data,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);

    localparam int IDX_W = (MAX_WAYPOINTS > 1) ? $clog2(MAX_WAYPOINTS) : 1;

    // Configuration registers.
    logic [15:0]       kp_lin_reg, ki_lin_reg, kd_lin_reg;
    logic [15:0]       kp_ang_reg, ki_ang_reg, kd_ang_reg;
    logic [RATE_W-1:0] rate_hz_reg;
    logic [3:0]        route_len_reg;

    // Controller state.
    wps_state_t         state_reg, state_next;
    logic [IDX_W-1:0]   target_reg;
    logic signed [15:0] lin_int_reg, ang_int_pos_reg, ang_int_neg_reg;
    logic [15:0]        prior_dist_reg;
    logic signed [15:0] prior_pos_reg, prior_neg_reg;

    // Per-transaction working registers.
    logic signed [15:0]     pos_x_reg, pos_y_reg, yaw_reg;
    logic [15:0]            dist_reg;
    logic signed [E_W-1:0]  err_reg;
    logic                   pos_dir_reg;
    logic                   lin_en_reg;
    logic                   q_neg_reg;
    logic signed [ACC_W-1:0] dterm_reg;
    logic [15:0]            lin_res_reg;
    logic signed [15:0]     ang_res_reg;
    logic                   done_res_reg;
    logic                   out_valid_reg;
    wps_out_t               out_data_reg;

    // Unit connections.
    logic                   in_fire;
    logic                   ram_we;
    logic [8:0]             slot9;
    logic [31:0]            ram_rdata;
    logic                   cordic_start;
    logic signed [16:0]     dx, dy;
    logic signed [XY_W-1:0] cordic_x;
    logic signed [Z_W-1:0]  cordic_z;
    logic                   cordic_done;
    logic                   mul_en;
    logic signed [A_W-1:0]  mul_a;
    logic signed [B_W-1:0]  mul_b;
    logic signed [P_W-1:0]  prod;
    logic                   div_start;
    logic [DIVN_W-1:0]      div_dividend;
    logic [DIVN_W-1:0]      div_quo;
    logic                   div_done;
    logic [RATE_W-1:0]      rate_eff;
    logic                   out_free;

    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign rate_eff = (rate_hz_reg == '0) ? RATE_W'(1) : rate_hz_reg;

    // Waypoint table; loads to slots beyond the table are dropped.
    assign slot9  = 9'(in_data.wp_index);
    assign ram_we = in_fire && (in_data.op == OP_LOAD) && (slot9 < 9'(MAX_WAYPOINTS));

    wps_ram #(
        .WIDTH (32),
        .DEPTH (MAX_WAYPOINTS)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (slot9[IDX_W-1:0]),
        .wdata ({in_data.pos_x, in_data.pos_y}),
        .raddr (target_reg),
        .rdata (ram_rdata)
    );

    assign dx = $signed({ram_rdata[31], ram_rdata[31:16]}) - $signed({pos_x_reg[15], pos_x_reg});
    assign dy = $signed({ram_rdata[15], ram_rdata[15:0]}) - $signed({pos_y_reg[15], pos_y_reg});

    wps_cordic #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_cordic (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (cordic_start),
        .dx      (dx),
        .dy      (dy),
        .mag_raw (cordic_x),
        .angle   (cordic_z),
        .done    (cordic_done)
    );

    wps_mul u_mul (
        .clk  (clk),
        .en   (mul_en),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    wps_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (rate_eff),
        .quotient (div_quo),
        .done     (div_done)
    );

    // Rounded shifts of the shared product.
    logic signed [ACC_W-1:0] prod_r9, prod_r4;
    assign prod_r9 = ACC_W'((prod + P_W'(256)) >>> 9);
    assign prod_r4 = ACC_W'((prod + P_W'(8)) >>> 4);

    // Distance and bearing once the CORDIC has finished.
    logic signed [P_W-1:0]   mag_full;
    logic [15:0]             dist_now;
    logic signed [Z_W-1:0]   bearing;
    logic signed [E_W-1:0]   adiff0, aabs, adiff1, err_now;
    logic                    arrive, aligned, pos_dir, lin_en, last_wp;
    logic [9:0]              len_eff;

    assign mag_full = (prod + (P_W'(1) <<< 27)) >>> 28;
    assign dist_now = (mag_full > P_W'(65535)) ? 16'hFFFF : mag_full[15:0];
    assign bearing  = (cordic_z + Z_W'(4)) >>> 3;
    assign adiff0   = E_W'(yaw_reg) - E_W'(bearing);
    assign aabs     = (adiff0 < 0) ? -adiff0 : adiff0;
    assign adiff1   = (adiff0 < 0) ? adiff0 + E_W'(TWO_PI_Q13) : adiff0;
    assign pos_dir  = (adiff1 > E_W'(PI_Q13)) && (adiff1 < E_W'(TWO_PI_Q13));
    assign err_now  = pos_dir ? E_W'(TWO_PI_Q13) - adiff1 : adiff1;
    assign arrive   = dist_now < 16'(ARRIVE_TOL);
    assign aligned  = aabs < E_W'(ALIGN_TOL);
    assign lin_en   = (aabs < E_W'(QUARTER_PI)) &&
                      ((dist_now > 16'(NEAR_DIST)) ||
                       ((dist_now < 16'(NEAR_DIST)) && aligned));
    assign len_eff  = (route_len_reg == 4'd0) ? 10'd1 :
                      ((10'(route_len_reg) > 10'(MAX_WAYPOINTS)) ? 10'(MAX_WAYPOINTS)
                                                               : 10'(route_len_reg));
    assign last_wp  = (10'(target_reg) + 10'd1) >= len_eff;

    // Turn update once the integral step is known. The negative-side
    // integral moves against the sign of the error product.
    logic signed [ACC_W-1:0] q_signed, int_sum, ang_sum, ang_clamped;
    logic signed [15:0]      int_new;
    logic signed [E_W:0]     err_step;

    assign err_step = pos_dir_reg ? (E_W+1)'(err_reg) - (E_W+1)'(prior_pos_reg)
                                  : (E_W+1)'(prior_neg_reg) - (E_W+1)'(err_reg);

    always_comb
    begin
        q_signed = q_neg_reg ? -ACC_W'($signed({1'b0, div_quo}))
                             : ACC_W'($signed({1'b0, div_quo}));
        if (pos_dir_reg)
        begin
            int_sum = ACC_W'(ang_int_pos_reg) + q_signed;
            if (int_sum > ACC_W'(ANG_LIMIT))
                int_sum = ACC_W'(ANG_LIMIT);
            int_new = wps_sat16(int_sum);
            ang_sum = prod_r9 + ACC_W'(int_new) + dterm_reg;
        end
        else
        begin
            int_sum = ACC_W'(ang_int_neg_reg) - q_signed;
            if (int_sum < -ACC_W'(ANG_LIMIT))
                int_sum = -ACC_W'(ANG_LIMIT);
            int_new = wps_sat16(int_sum);
            ang_sum = ACC_W'(int_new) - prod_r9 - dterm_reg;
        end
        if (ang_sum > ACC_W'(ANG_LIMIT))
            ang_clamped = ACC_W'(ANG_LIMIT);
        else if (ang_sum < -ACC_W'(ANG_LIMIT))
            ang_clamped = -ACC_W'(ANG_LIMIT);
        else
            ang_clamped = ang_sum;
    end

    // Forward update.
    logic signed [ACC_W-1:0] lint_sum, lin_sum, lin_clamped;
    logic signed [16:0]      dist_diff;

    assign dist_diff = $signed({1'b0, dist_reg}) - $signed({1'b0, prior_dist_reg});

    always_comb
    begin
        lint_sum = ACC_W'(lin_int_reg) + prod_r4;
        if (lint_sum > ACC_W'(LIN_LIMIT))
            lint_sum = ACC_W'(LIN_LIMIT);
        lin_sum = prod_r4 + ACC_W'(lin_int_reg) + dterm_reg;
        if (lin_sum > ACC_W'(LIN_LIMIT))
            lin_clamped = ACC_W'(LIN_LIMIT);
        else if (lin_sum < 0)
            lin_clamped = '0;
        else
            lin_clamped = lin_sum;
    end

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:     if (in_fire && in_data.op != OP_LOAD) state_next = ST_FETCH;
            ST_FETCH:    state_next = ST_CORDIC;
            ST_CORDIC:   if (cordic_done) state_next = ST_GAIN;
            ST_GAIN:     state_next = ST_DIST;
            ST_DIST:
            begin
                if (arrive)
                    state_next = ST_DONE;
                else if (!aligned)
                    state_next = ST_ANG_KI;
                else if (lin_en)
                    state_next = ST_LIN_KI;
                else
                    state_next = ST_DONE;
            end
            ST_ANG_KI:   state_next = ST_ANG_DR;
            ST_ANG_DR:   state_next = ST_ANG_KD;
            ST_ANG_KD:   state_next = ST_ANG_KP;
            ST_ANG_KP:   state_next = ST_ANG_WAIT;
            ST_ANG_WAIT: if (div_done) state_next = lin_en_reg ? ST_LIN_KI : ST_DONE;
            ST_LIN_KI:   state_next = ST_LIN_DR;
            ST_LIN_DR:   state_next = ST_LIN_KD;
            ST_LIN_KD:   state_next = ST_LIN_KP;
            ST_LIN_KP:   state_next = ST_LIN_SUM;
            ST_LIN_SUM:  state_next = ST_DONE;
            ST_DONE:     if (out_free) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    // Unit controls and multiplier operands for each step.
    always_comb
    begin
        in_ready     = 1'b0;
        cordic_start = 1'b0;
        div_start    = 1'b0;
        div_dividend = DIVN_W'((prod < 0 ? -prod : prod) >>> 9);
        mul_en       = 1'b0;
        mul_a        = '0;
        mul_b        = '0;
        case (state_reg)
            ST_IDLE:  in_ready = 1'b1;
            ST_FETCH: cordic_start = 1'b1;
            ST_GAIN:
            begin
                mul_en = 1'b1;
                mul_a  = (cordic_x < 0) ? '0 : cordic_x;
                mul_b  = B_W'(GAIN_INV_Q16);
            end
            ST_ANG_KI:
            begin
                mul_en = 1'b1;
                mul_a  = A_W'(err_reg);
                mul_b  = $signed({2'b0, ki_ang_reg});
            end
            ST_ANG_DR:
            begin
                div_start = 1'b1;
                mul_en    = 1'b1;
                mul_a     = A_W'(err_step);
                mul_b     = $signed(B_W'(rate_eff));
            end
            ST_ANG_KD:
            begin
                mul_en = 1'b1;
                mul_a  = prod[A_W-1:0];
                mul_b  = $signed({2'b0, kd_ang_reg});
            end
            ST_ANG_KP:
            begin
                mul_en = 1'b1;
                mul_a  = A_W'(err_reg);
                mul_b  = $signed({2'b0, kp_ang_reg});
            end
            ST_LIN_KI:
            begin
                mul_en = 1'b1;
                mul_a  = $signed(A_W'(dist_reg));
                mul_b  = $signed({2'b0, ki_lin_reg});
            end
            ST_LIN_DR:
            begin
                mul_en = 1'b1;
                mul_a  = A_W'(dist_diff);
                mul_b  = $signed(B_W'(rate_eff));
            end
            ST_LIN_KD:
            begin
                mul_en = 1'b1;
                mul_a  = prod[A_W-1:0];
                mul_b  = $signed({2'b0, kd_lin_reg});
            end
            ST_LIN_KP:
            begin
                mul_en = 1'b1;
                mul_a  = $signed(A_W'(dist_reg));
                mul_b  = $signed({2'b0, kp_lin_reg});
            end
            default: ;
        endcase
    end

    // Configuration and controller state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            kp_lin_reg      <= 16'd128;
            ki_lin_reg      <= 16'd13;
            kd_lin_reg      <= 16'd26;
            kp_ang_reg      <= 16'd435;
            ki_ang_reg      <= 16'd77;
            kd_ang_reg      <= 16'd51;
            rate_hz_reg     <= RATE_W'(10);
            route_len_reg   <= 4'd5;
            target_reg      <= '0;
            lin_int_reg     <= '0;
            ang_int_pos_reg <= '0;
            ang_int_neg_reg <= '0;
            prior_dist_reg  <= '0;
            prior_pos_reg   <= '0;
            prior_neg_reg   <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_we)
            begin
                case (cfg_addr)
                    REG_KP_LIN:    kp_lin_reg    <= cfg_wdata;
                    REG_KI_LIN:    ki_lin_reg    <= cfg_wdata;
                    REG_KD_LIN:    kd_lin_reg    <= cfg_wdata;
                    REG_KP_ANG:    kp_ang_reg    <= cfg_wdata;
                    REG_KI_ANG:    ki_ang_reg    <= cfg_wdata;
                    REG_KD_ANG:    kd_ang_reg    <= cfg_wdata;
                    REG_RATE:      rate_hz_reg   <= cfg_wdata[RATE_W-1:0];
                    REG_ROUTE_LEN: route_len_reg <= cfg_wdata[3:0];
                    default: ;
                endcase
            end

            case (state_reg)
                ST_DIST:
                begin
                    if (arrive)
                    begin
                        if (!last_wp)
                        begin
                            target_reg      <= target_reg + 1'b1;
                            lin_int_reg     <= '0;
                            ang_int_pos_reg <= '0;
                            ang_int_neg_reg <= '0;
                            prior_dist_reg  <= '0;
                            prior_pos_reg   <= '0;
                            prior_neg_reg   <= '0;
                        end
                    end
                    else if (aligned)
                    begin
                        ang_int_pos_reg <= '0;
                        ang_int_neg_reg <= '0;
                    end
                end
                ST_ANG_WAIT:
                begin
                    if (div_done)
                    begin
                        if (pos_dir_reg)
                        begin
                            ang_int_pos_reg <= int_new;
                            ang_int_neg_reg <= '0;
                            prior_pos_reg   <= wps_sat16(ACC_W'(err_reg));
                        end
                        else
                        begin
                            ang_int_neg_reg <= int_new;
                            ang_int_pos_reg <= '0;
                            prior_neg_reg   <= wps_sat16(ACC_W'(err_reg));
                        end
                    end
                end
                ST_LIN_DR:
                begin
                    if (dist_reg < 16'(INTEG_DIST))
                        lin_int_reg <= wps_sat16(lint_sum);
                end
                ST_LIN_SUM:
                begin
                    prior_dist_reg <= dist_reg;
                end
                default: ;
            endcase

            if (state_reg == ST_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Working registers of the transaction in flight.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            pos_x_reg <= in_data.pos_x;
            pos_y_reg <= in_data.pos_y;
            yaw_reg   <= in_data.yaw_angle;
        end
        case (state_reg)
            ST_DIST:
            begin
                dist_reg     <= dist_now;
                err_reg      <= err_now;
                pos_dir_reg  <= pos_dir;
                lin_en_reg   <= lin_en;
                lin_res_reg  <= '0;
                ang_res_reg  <= '0;
                done_res_reg <= arrive && last_wp;
            end
            ST_ANG_DR:   q_neg_reg <= prod < 0;
            ST_ANG_KP:   dterm_reg <= prod_r9;
            ST_ANG_WAIT: if (div_done) ang_res_reg <= ang_clamped[15:0];
            ST_LIN_KP:   dterm_reg <= prod_r4;
            ST_LIN_SUM:  lin_res_reg <= lin_clamped[15:0];
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_data_reg.linear_cmd  <= lin_res_reg[11:0];
                    out_data_reg.angular_cmd <= ang_res_reg;
                    out_data_reg.target_slot <= 3'(9'(target_reg));
                    out_data_reg.route_done  <= done_res_reg;
                end
            end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

// ===== rtl/wps_checker.sv =====
module wps_checker import wps_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input wps_in_t     in_data,
    input logic        out_valid,
    input logic        out_ready,
    input wps_out_t    out_data
);

    // A result waiting for the consumer holds its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // A waypoint load finishes in the cycle it is accepted.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.op == OP_LOAD |=> in_ready)
        else $error("input stalled after a waypoint load");

    // A pose transaction keeps the input closed while it is worked on.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_data.op != OP_LOAD |=> !in_ready ##1 !in_ready)
        else $error("input reopened during a pose update");

    // Once the route is complete both commands are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.route_done |->
            out_data.linear_cmd == 12'd0 && out_data.angular_cmd == 16'sd0)
        else $error("motion commanded at route end");

endmodule

bind waypoint_pid_steering wps_checker u_wps_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import wps_pkg::*;

    localparam int N_WP      = 8;
    localparam int LIN_MAX   = 2048;
    localparam int ANG_MAX   = 17408;
    localparam int CYCLE_CAP = 900000;

    // Clock and reset.
    logic clk;
    logic rst_n;

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Block ports. Every input starts at a known value.
    logic        in_valid = 1'b0;
    logic        in_ready;
    wps_in_t     in_data  = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    wps_out_t    out_data;
    logic        cfg_we    = 1'b0;
    logic [2:0]  cfg_addr  = REG_KP_LIN;
    logic [15:0] cfg_wdata = '0;

    waypoint_pid_steering dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Predictor state: the controller's copy of the route table, its PID
    // memory and the gains that are currently programmed.
    logic signed [15:0] route_x [N_WP];
    logic signed [15:0] route_y [N_WP];
    int unsigned        aim_slot;
    longint             lin_acc, turn_acc_pos, turn_acc_neg;
    longint             last_dist, last_err_pos, last_err_neg;
    longint             gain_reg [8];

    // Transactions waiting to be driven, and commands expected back.
    wps_in_t  pose_queue [$];
    wps_out_t cmd_queue  [$];

    int  error_count   = 0;
    int  cycle_count   = 0;
    bit  tail_quiet    = 1'b0;  // no idling in the last part of the run
    bit  hold_receiver = 1'b0;  // request for a long stall on the result side
    int  send_gap      = 0;
    int  sink_gap      = 0;

    function automatic longint shift_dn(longint v, int k);
        return v >>> k;
    endfunction

    function automatic longint round_dn(longint v, int k);
        return (v + (longint'(1) << (k - 1))) >>> k;
    endfunction

    function automatic longint limit(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic longint arctan_q16(int i);
        longint tbl [17] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512, 256,
                             128, 64, 32, 16, 8, 4, 2, 1};
        return i < 17 ? tbl[i] : 0;
    endfunction

    // Vectoring CORDIC: bearing in Q3.13 and range in Q8.8 from an offset.
    task automatic bearing_range(input longint dx, input longint dy,
                                 output longint bearing, output longint range);
        longint x, y, z, xs, ys;
        x = dx * 4096;
        y = dy * 4096;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? 205887 : -205887;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < 16; i++)
        begin
            xs = shift_dn(x, i);
            ys = shift_dn(y, i);
            if (y >= 0)
            begin
                x += ys; y -= xs; z += arctan_q16(i);
            end
            else
            begin
                x -= ys; y += xs; z -= arctan_q16(i);
            end
        end
        bearing = round_dn(z, 3);
        if (x < 0)
            x = 0;
        range = limit((x * 39797 + (longint'(1) << 27)) >>> 28, 0, 65535);
    endtask

    task automatic clear_pid_memory();
        lin_acc = 0; turn_acc_pos = 0; turn_acc_neg = 0;
        last_dist = 0; last_err_pos = 0; last_err_neg = 0;
    endtask

    // Work out the steering command that one transaction produces, if any.
    task automatic predict_steering(input wps_in_t t);
        longint   rate, len, dx, dy, span, bearing, adiff, aabs, e, d;
        longint   lin, ang;
        bit       aligned, done;
        wps_out_t r;
        lin = 0; ang = 0; aligned = 0; done = 0;
        if (t.op == OP_LOAD)
        begin
            route_x[t.wp_index] = t.pos_x;
            route_y[t.wp_index] = t.pos_y;
            return;
        end
        rate = gain_reg[REG_RATE] != 0 ? gain_reg[REG_RATE] : 1;
        len  = limit(gain_reg[REG_ROUTE_LEN], 1, N_WP);
        dx = longint'(route_x[aim_slot]) - longint'(t.pos_x);
        dy = longint'(route_y[aim_slot]) - longint'(t.pos_y);
        bearing_range(dx, dy, bearing, span);
        if (span >= ARRIVE_TOL)
        begin
            adiff = longint'(t.yaw_angle) - bearing;
            aabs  = adiff < 0 ? -adiff : adiff;
            if (aabs >= ALIGN_TOL)
            begin
                if (adiff < 0)
                    adiff += TWO_PI_Q13;
                if (adiff > PI_Q13 && adiff < TWO_PI_Q13)
                begin
                    // Shorter way round is a positive turn.
                    e = TWO_PI_Q13 - adiff;
                    turn_acc_neg = 0;
                    turn_acc_pos += (e * gain_reg[REG_KI_ANG]) / (rate * 512);
                    if (turn_acc_pos > ANG_MAX)
                        turn_acc_pos = ANG_MAX;
                    turn_acc_pos = limit(turn_acc_pos, -32768, 32767);
                    d = round_dn((e - last_err_pos) * rate * gain_reg[REG_KD_ANG], 9);
                    ang = round_dn(e * gain_reg[REG_KP_ANG], 9) + turn_acc_pos + d;
                    last_err_pos = limit(e, -32768, 32767);
                end
                else
                begin
                    e = adiff;
                    turn_acc_pos = 0;
                    turn_acc_neg += (-e * gain_reg[REG_KI_ANG]) / (rate * 512);
                    if (turn_acc_neg < -ANG_MAX)
                        turn_acc_neg = -ANG_MAX;
                    turn_acc_neg = limit(turn_acc_neg, -32768, 32767);
                    d = round_dn((last_err_neg - e) * rate * gain_reg[REG_KD_ANG], 9);
                    ang = -(round_dn(e * gain_reg[REG_KP_ANG], 9) - turn_acc_neg + d);
                    last_err_neg = limit(e, -32768, 32767);
                end
                ang = limit(ang, -ANG_MAX, ANG_MAX);
            end
            else
            begin
                turn_acc_pos = 0;
                turn_acc_neg = 0;
                aligned = 1'b1;
            end
            // Forward PID runs only when roughly facing the waypoint.
            if (aabs < QUARTER_PI &&
                (span > NEAR_DIST || (span < NEAR_DIST && aligned)))
            begin
                if (span < INTEG_DIST)
                begin
                    lin_acc += round_dn(span * gain_reg[REG_KI_LIN], 4);
                    if (lin_acc > LIN_MAX)
                        lin_acc = LIN_MAX;
                    lin_acc = limit(lin_acc, -32768, 32767);
                end
                d = round_dn((span - last_dist) * rate * gain_reg[REG_KD_LIN], 4);
                lin = round_dn(span * gain_reg[REG_KP_LIN], 4) + lin_acc + d;
                lin = limit(lin, 0, LIN_MAX);
                last_dist = span;
            end
        end
        else if (longint'(aim_slot) + 1 >= len)
            done = 1'b1;
        else
        begin
            aim_slot++;
            clear_pid_memory();
        end
        r.linear_cmd  = lin[11:0];
        r.angular_cmd = ang[15:0];
        r.target_slot = aim_slot[2:0];
        r.route_done  = done;
        cmd_queue.push_back(r);
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("MISMATCH at cycle %0d: %s got %0d expected %0d", cycle_count, what, got, want);
        error_count++;
    endtask

    // Driver: offers queued transactions, with random gaps between them.
    // The predictor runs at the moment a transaction is accepted.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                predict_steering(in_data);
            if (!(in_valid && !in_ready))
            begin
                if (send_gap > 0)
                begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end
                else if (pose_queue.size() > 0)
                begin
                    in_data  <= pose_queue.pop_front();
                    in_valid <= 1'b1;
                    if (!tail_quiet && $urandom_range(0, 9) == 0)
                        send_gap <= $urandom_range(1, 13);
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // Monitor: accepts results, stalls at random, and checks each command
    // against the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            sink_gap  <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (cmd_queue.size() == 0)
                    report_mismatch("unexpected result, route_done", out_data.route_done, -1);
                else
                begin
                    wps_out_t w;
                    w = cmd_queue.pop_front();
                    if (out_data.linear_cmd !== w.linear_cmd)
                        report_mismatch("linear_cmd", out_data.linear_cmd, w.linear_cmd);
                    if (out_data.angular_cmd !== w.angular_cmd)
                        report_mismatch("angular_cmd", out_data.angular_cmd, w.angular_cmd);
                    if (out_data.target_slot !== w.target_slot)
                        report_mismatch("target_slot", out_data.target_slot, w.target_slot);
                    if (out_data.route_done !== w.route_done)
                        report_mismatch("route_done", out_data.route_done, w.route_done);
                end
            end
            if (hold_receiver)
                out_ready <= 1'b0;
            else if (sink_gap > 0)
            begin
                sink_gap  <= sink_gap - 1;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= 1'b1;
                if (!tail_quiet && $urandom_range(0, 7) == 0)
                    sink_gap <= $urandom_range(1, 13);
            end
        end
    end

    // Long receiver stall, counted in its own process while the driver keeps
    // offering transactions so the block backs up.
    initial
    begin
        wait (cycle_count == 3000);
        hold_receiver = 1'b1;
        repeat (500) @(posedge clk);
        hold_receiver = 1'b0;
    end

    // Watchdog on total run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("Test completed with failures");
            $finish;
        end
    end

    function automatic wps_in_t load_item(int slot, int x, int y);
        wps_in_t t;
        t.op = OP_LOAD;
        t.wp_index = slot[2:0];
        t.pos_x = x[15:0];
        t.pos_y = y[15:0];
        t.yaw_angle = 16'($urandom);
        return t;
    endfunction

    function automatic wps_in_t pose_item(int x, int y, int yaw);
        wps_in_t t;
        t.op = ~OP_LOAD;
        t.wp_index = 3'($urandom);
        t.pos_x = x[15:0];
        t.pos_y = y[15:0];
        t.yaw_angle = yaw[15:0];
        return t;
    endfunction

    function automatic int rand_yaw();
        return int'($urandom_range(0, 2 * PI_Q13)) - PI_Q13;
    endfunction

    function automatic int rand_coord();
        return int'($urandom_range(0, 65535)) - 32768;
    endfunction

    // Wait until every queued transaction has been taken and every result
    // has come back, then let the block settle.
    task automatic drain();
        wait (pose_queue.size() == 0 && !in_valid);
        wait (cmd_queue.size() == 0);
        repeat (100) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int value);
        cfg_addr  <= idx;
        cfg_wdata <= value[15:0];
        cfg_we    <= 1'b1;
        @(posedge clk);
        cfg_we    <= 1'b0;
        gain_reg[idx] = (idx == REG_RATE) ? (value & 'h3FF) :
                        (idx == REG_ROUTE_LEN) ? (value & 'hF) : (value & 'hFFFF);
        @(posedge clk);
    endtask

    task automatic program_gains(int kpl, int kil, int kdl, int kpa, int kia, int kda,
                                 int rate, int len);
        write_reg(REG_KP_LIN, kpl);
        write_reg(REG_KI_LIN, kil);
        write_reg(REG_KD_LIN, kdl);
        write_reg(REG_KP_ANG, kpa);
        write_reg(REG_KI_ANG, kia);
        write_reg(REG_KD_ANG, kda);
        write_reg(REG_RATE, rate);
        write_reg(REG_ROUTE_LEN, len);
    endtask

    // Random phase: load a full route, then fly poses near the waypoints in
    // turn so arrivals and advances happen; some poses are far away and some items reload a slot.
    task automatic route_phase(int n_items);
        int wx, wy, k, slot;
        int plan_x [N_WP];
        int plan_y [N_WP];
        for (int s = 0; s < N_WP; s++)
        begin
            plan_x[s] = rand_coord();
            plan_y[s] = rand_coord();
            pose_queue.push_back(load_item(s, plan_x[s], plan_y[s]));
        end
        k = 0;
        for (int i = 0; i < n_items; i++)
        begin
            case ($urandom_range(0, 9))
                0:
                begin
                    slot = int'($urandom_range(0, 7));
                    plan_x[slot] = rand_coord();
                    plan_y[slot] = rand_coord();
                    pose_queue.push_back(load_item(slot, plan_x[slot], plan_y[slot]));
                end
                1: pose_queue.push_back(pose_item(rand_coord(), rand_coord(), rand_yaw()));
                default:
                begin
                    // Approach the slot the controller is likely aiming at by
                    // then; a guess is fine, arrivals just come less often.
                    wx = plan_x[k % N_WP];
                    wy = plan_y[k % N_WP];
                    if ($urandom_range(0, 3) == 0)
                    begin
                        wx += int'($urandom_range(0, 8)) - 4;
                        wy += int'($urandom_range(0, 8)) - 4;
                        k++;
                    end
                    else
                    begin
                        wx += int'($urandom_range(0, 600)) - 300;
                        wy += int'($urandom_range(0, 600)) - 300;
                    end
                    pose_queue.push_back(pose_item(int'(limit(wx, -32768, 32767)),
                        int'(limit(wy, -32768, 32767)), rand_yaw()));
                end
            endcase
        end
    endtask

    initial
    begin
        for (int s = 0; s < N_WP; s++)
        begin
            route_x[s] = '0; route_y[s] = '0;
        end
        aim_slot = 0;
        clear_pid_memory();
        gain_reg = '{128, 13, 26, 435, 77, 51, 10, 5};

        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at reset gains: extremes of position and heading,
        // arrival, aligned heading, a distance of exactly the near limit.
        pose_queue.push_back(load_item(0, 0, 0));
        pose_queue.push_back(load_item(1, 32767, -32768));
        pose_queue.push_back(load_item(2, -32768, 32767));
        pose_queue.push_back(load_item(3, 1000, 1000));
        pose_queue.push_back(load_item(4, 0, 0));
        pose_queue.push_back(pose_item(-32768, -32768, PI_Q13));
        pose_queue.push_back(pose_item(32767, 32767, -PI_Q13));
        pose_queue.push_back(pose_item(-500, 0, 0));
        pose_queue.push_back(pose_item(-26, 0, 0));
        pose_queue.push_back(pose_item(-20, 0, 0));
        pose_queue.push_back(pose_item(0, 100, 0));
        pose_queue.push_back(pose_item(3, 2, 0));
        pose_queue.push_back(pose_item(32767, -32768, 100));
        pose_queue.push_back(pose_item(32760, -32760, 0));
        pose_queue.push_back(pose_item(-32768, 32767, 25000));
        pose_queue.push_back(pose_item(1000, 1000, 0));
        pose_queue.push_back(pose_item(0, 0, -6000));
        pose_queue.push_back(pose_item(0, 0, 0));
        pose_queue.push_back(pose_item(0, 0, 0));
        drain();

        // Zero-valued extremes, then full-scale extremes; route lengths out
        // of range in both directions.
        program_gains(0, 0, 0, 0, 0, 0, 0, 0);
        route_phase(60);
        drain();
        program_gains(65535, 65535, 65535, 65535, 65535, 65535, 1023, 15);
        route_phase(60);
        drain();
        program_gains(65535, 65535, 65535, 65535, 65535, 65535, 1000, 8);
        route_phase(80);
        drain();
        program_gains(128, 13, 26, 435, 77, 51, 1, 1);
        route_phase(60);
        drain();

        // Mostly random settings, with a pause until all results are back.
        for (int p = 0; p < 5; p++)
        begin
            program_gains($urandom_range(0, 65535), $urandom_range(0, 2000),
                          $urandom_range(0, 500), $urandom_range(0, 65535),
                          $urandom_range(0, 65535), $urandom_range(0, 2000),
                          $urandom_range(1, 1000), $urandom_range(1, 8));
            route_phase(80);
            drain();
        end

        // Final stretch runs with no idling at all.
        tail_quiet = 1'b1;
        program_gains(128, 13, 26, 435, 77, 51, 10, 5);
        route_phase(90);
        drain();

        if (error_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
